// ===== rtl/core/ntlr_pkg.sv =====
`default_nettype none

package ntlr_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int EXP_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W = 16;
  localparam int TIME_W = 32;
  localparam int RSSI_W = 8;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;

  localparam logic [ADDR_W-1:0] FREE_MARKER_RST = 16'hFFFF;

  // one table entry as it moves along the ring
  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [TIME_W-1:0]        tstamp;
    logic signed [RSSI_W-1:0] rssi;
  } entry_t;

  // direct write into one cell
  typedef struct packed {
    logic   en;
    entry_t data;
  } entry_wr_t;

  // scan outcome handed to the control
  typedef struct packed {
    logic              hit;
    logic              took_free;
    logic              did_evict;
    logic [IDX_W-1:0]  chosen;
    logic [ADDR_W-1:0] evicted;
    logic [EXP_W-1:0]  expired;
  } scan_sum_t;

endpackage

`default_nettype wire

// ===== rtl/core/ntlr_cell.sv =====
`default_nettype none

module ntlr_cell
  import ntlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      shift,
  input  wire entry_t    d_in,
  input  wire entry_wr_t wr,
  output entry_t         q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.addr   <= FREE_MARKER_RST;
      q.tstamp <= '0;
      q.rssi   <= '0;
    end else if (shift) begin
      q <= d_in;
    end else if (wr.en) begin
      q <= wr.data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ntlr_scan.sv =====
`default_nettype none

module ntlr_scan
  import ntlr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              step,
  input  wire logic [ADDR_W-1:0] fm,
  input  wire logic [ADDR_W-1:0] key_addr,
  input  wire logic [TIME_W-1:0] key_now,
  input  wire entry_t            head,
  output entry_t                 tail,
  output logic                   last,
  output scan_sum_t              sum
);

  logic [IDX_W-1:0]  k;
  logic              hit;
  logic              have_free;
  logic              have_old;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  old_idx;
  logic [TIME_W-1:0] old_time;
  logic [ADDR_W-1:0] old_addr;
  logic [EXP_W-1:0]  expired;

  logic is_free, is_match, is_exp, active;

  always_comb begin
    active   = !hit;
    is_free  = (head.addr == fm);
    is_match = !is_free && (head.addr == key_addr);
    is_exp   = !is_free && !is_match && (head.tstamp > key_now);
    tail     = head;
    // expired entry leaves the head already freed, rssi kept
    if (active && is_exp) begin
      tail.addr   = fm;
      tail.tstamp = '0;
    end
  end

  assign last = (k == IDX_W'(TABLE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst || start) begin
      k         <= '0;
      hit       <= 1'b0;
      have_free <= 1'b0;
      have_old  <= 1'b0;
      expired   <= '0;
    end else if (step) begin
      k <= k + 1'b1;
      if (active) begin
        if (is_free) begin
          have_free <= 1'b1;
          free_idx  <= k;
        end else if (is_match) begin
          hit     <= 1'b1;
          hit_idx <= k;
        end else if (is_exp) begin
          have_free <= 1'b1;
          free_idx  <= k;
          expired   <= expired + 1'b1;
        end else if (!have_old || head.tstamp < old_time) begin
          have_old <= 1'b1;
          old_time <= head.tstamp;
          old_idx  <= k;
          old_addr <= head.addr;
        end
      end
    end
  end

  always_comb begin
    sum.hit       = hit;
    sum.took_free = !hit && have_free;
    sum.did_evict = !hit && !have_free;
    sum.chosen    = hit ? hit_idx : (have_free ? free_idx : old_idx);
    sum.evicted   = sum.did_evict ? old_addr : fm;
    sum.expired   = expired;
  end

endmodule

`default_nettype wire

// ===== rtl/core/neighbor_table_lookup_replace.sv =====
// the ring of entry cells steps one entry past the head per cycle while scanning;
// a new beat is taken only in idle, not before the last one's result is in the
//   output register, and the update waits while that register is stalled
// reset: synchronous, all entries free at once (no clearing sweep), free
//   marker back to 16'hFFFF, no result pending
`default_nettype none

module neighbor_table_lookup_replace
  import ntlr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_wr_en,
  input  wire logic [ADDR_W-1:0]        cfg_wr_data,
  // input beat
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ADDR_W-1:0]        rx_addr,
  input  wire logic [TIME_W-1:0]        now_ticks,
  input  wire logic signed [RSSI_W-1:0] rx_rssi,
  // result beat
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [SLOT_W-1:0]             slot_index,
  output logic                          was_hit,
  output logic                          took_free,
  output logic                          did_evict,
  output logic [ADDR_W-1:0]             evicted_addr,
  output logic [CNT_W-1:0]              expired_count
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;

  // free marker register
  logic [ADDR_W-1:0] free_marker;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_marker <= FREE_MARKER_RST;
    end else if (cfg_wr_en) begin
      free_marker <= cfg_wr_data;
    end
  end

  // latched key of the beat under work
  logic [ADDR_W-1:0]        key_addr;
  logic [TIME_W-1:0]        key_now;
  logic signed [RSSI_W-1:0] key_rssi;

  logic start, step, last, upd_fire;
  scan_sum_t sum;

  assign in_stall = (state != ST_IDLE);
  assign start    = in_valid && (state == ST_IDLE);
  assign step     = (state == ST_SCAN);
  // the update waits until the output register is free
  assign upd_fire = (state == ST_UPDATE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (start) begin
      key_addr <= rx_addr;
      key_now  <= now_ticks;
      key_rssi <= rx_rssi;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (last) state_next = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring of entry cells: cell 0 is the head, the head entry (freed if it
  // expired) re-enters at the tail, so after a full pass every entry is
  // back at its own index
  entry_t    ring_q [TABLE_ENTRIES];
  entry_t    ring_d [TABLE_ENTRIES];
  entry_wr_t ring_wr [TABLE_ENTRIES];
  entry_t    tail;
  entry_t    upd_data;

  always_comb begin
    upd_data.addr   = key_addr;
    upd_data.tstamp = key_now;
    upd_data.rssi   = key_rssi;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign ring_d[k] = tail;
    end else begin : g_mid
      assign ring_d[k] = ring_q[k + 1];
    end

    // chosen slot gets the new address, time and rssi
    assign ring_wr[k] = '{en: upd_fire && (sum.chosen == IDX_W'(k)), data: upd_data};

    ntlr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (step),
      .d_in  (ring_d[k]),
      .wr    (ring_wr[k]),
      .q     (ring_q[k])
    );
  end

  // head evaluation and running free / oldest / hit tracking
  ntlr_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .step     (step),
    .fm       (free_marker),
    .key_addr (key_addr),
    .key_now  (key_now),
    .head     (ring_q[0]),
    .tail     (tail),
    .last     (last),
    .sum      (sum)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      slot_index    <= SLOT_W'(sum.chosen);
      was_hit       <= sum.hit;
      took_free     <= sum.took_free;
      did_evict     <= sum.did_evict;
      evicted_addr  <= sum.evicted;
      expired_count <= CNT_W'(sum.expired);
    end
  end

  // a result beat appears only out of the update step
  a_out_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPDATE))
    else $error("result raised outside update");

  // exactly one of hit, free slot, eviction per beat
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({was_hit, took_free, did_evict}))
    else $error("outcome flags not one-hot");

  // without eviction the displaced address is the free marker
  a_evict_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !did_evict) |-> (evicted_addr == free_marker))
    else $error("evicted address without eviction");

  // no new beat taken while the scan is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> in_stall)
    else $error("input taken during scan");

endmodule

`default_nettype wire
